FILE: rtl/cspr_pkg.sv
// Shared types and constants for the console serial port register block.
package cspr_pkg;

    // Item modes
    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    // Register addresses (octal)
    localparam logic [17:0] ADDR_RCSR = 18'o777560;
    localparam logic [17:0] ADDR_RBUF = 18'o777562;
    localparam logic [17:0] ADDR_XCSR = 18'o777564;
    localparam logic [17:0] ADDR_XBUF = 18'o777566;

    // Status bit positions and masks
    localparam int unsigned BIT_DONE_POS = 7;
    localparam int unsigned BIT_IE_POS   = 6;
    localparam logic [15:0] BIT_DONE     = 16'o200;
    localparam logic [15:0] BITS_DONE_IE = 16'o300;
    localparam logic [7:0]  PENDING      = 8'h80;

    // One-shot transmit request phase
    typedef enum logic [1:0] {
        PHASE_IDLE  = 2'd0,
        PHASE_ARMED = 2'd1,
        PHASE_GIVEN = 2'd2
    } tx_phase_t;

    // One input beat
    typedef struct packed {
        logic [1:0]  mode;
        logic [17:0] address;
        logic [15:0] write_data;
        logic        rx_avail;
        logic [7:0]  rx_char;
    } item_t;

    // One result beat
    typedef struct packed {
        logic [15:0] read_data;
        logic        bus_error;
        logic        tx_valid;
        logic [6:0]  tx_char;
        logic        rx_irq;
        logic        tx_irq;
    } result_t;

endpackage

FILE: rtl/cspr_core.sv
// Register state and single-pass update logic of the console serial port.
module cspr_core
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  cspr_pkg::item_t item,
    output cspr_pkg::result_t res
);

    logic [15:0]         rx_status_reg, rx_status_next;
    logic [15:0]         tx_status_reg, tx_status_next;
    logic [6:0]          rx_buffer_reg, rx_buffer_next;
    logic [7:0]          tx_buffer_reg, tx_buffer_next;
    cspr_pkg::tx_phase_t phase_reg, phase_next;
    logic                skipped_reg, skipped_next;

    // State registers, updated once per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_status_reg <= '0;
            tx_status_reg <= cspr_pkg::BIT_DONE;
            rx_buffer_reg <= '0;
            tx_buffer_reg <= '0;
            phase_reg     <= cspr_pkg::PHASE_IDLE;
            skipped_reg   <= 1'b0;
        end
        else if (fire)
        begin
            rx_status_reg <= rx_status_next;
            tx_status_reg <= tx_status_next;
            rx_buffer_reg <= rx_buffer_next;
            tx_buffer_reg <= tx_buffer_next;
            phase_reg     <= phase_next;
            skipped_reg   <= skipped_next;
        end
    end

    // Next state and result for the current item
    always_comb
    begin
        logic [15:0] xcsr_wr;
        rx_status_next = rx_status_reg;
        tx_status_next = tx_status_reg;
        rx_buffer_next = rx_buffer_reg;
        tx_buffer_next = tx_buffer_reg;
        phase_next     = phase_reg;
        skipped_next   = skipped_reg;
        res            = '0;
        xcsr_wr        = (tx_status_reg & cspr_pkg::BIT_DONE)
                       | (item.write_data & ~cspr_pkg::BIT_DONE);

        unique case (item.mode)
            cspr_pkg::MODE_READ:
            begin
                unique case (item.address)
                    cspr_pkg::ADDR_RCSR: res.read_data = rx_status_reg;
                    cspr_pkg::ADDR_RBUF:
                    begin
                        rx_status_next = rx_status_reg & ~cspr_pkg::BIT_DONE;
                        res.read_data  = {9'd0, rx_buffer_reg};
                    end
                    cspr_pkg::ADDR_XCSR: res.read_data = tx_status_reg;
                    cspr_pkg::ADDR_XBUF: res.read_data = {8'd0, tx_buffer_reg};
                    default:             res.bus_error = 1'b1;
                endcase
            end
            cspr_pkg::MODE_WRITE:
            begin
                unique case (item.address)
                    cspr_pkg::ADDR_RCSR:
                        rx_status_next = (rx_status_reg & cspr_pkg::BIT_DONE)
                                       | (item.write_data & ~cspr_pkg::BIT_DONE);
                    cspr_pkg::ADDR_RBUF:
                        rx_status_next = rx_status_reg & ~cspr_pkg::BIT_DONE;
                    cspr_pkg::ADDR_XCSR:
                    begin
                        tx_status_next = xcsr_wr;
                        // ready with enable arms the one-shot; a given one re-idles
                        if ((xcsr_wr & cspr_pkg::BITS_DONE_IE) == cspr_pkg::BITS_DONE_IE
                            && phase_reg == cspr_pkg::PHASE_IDLE)
                            phase_next = cspr_pkg::PHASE_ARMED;
                        else if (phase_reg == cspr_pkg::PHASE_GIVEN)
                            phase_next = cspr_pkg::PHASE_IDLE;
                    end
                    cspr_pkg::ADDR_XBUF:
                    begin
                        res.tx_valid   = 1'b1;
                        res.tx_char    = item.write_data[6:0];
                        tx_buffer_next = {1'b1, item.write_data[6:0]};
                        tx_status_next = tx_status_reg & ~cspr_pkg::BIT_DONE;
                        phase_next     = cspr_pkg::PHASE_IDLE;
                    end
                    default: res.bus_error = 1'b1;
                endcase
            end
            cspr_pkg::MODE_TICK:
            begin
                // receiver: skip one tick, then take a non-null character
                if (!rx_status_reg[cspr_pkg::BIT_DONE_POS])
                begin
                    if (!skipped_reg)
                        skipped_next = 1'b1;
                    else if (item.rx_avail)
                    begin
                        skipped_next = 1'b0;
                        if (item.rx_char != 8'd0)
                        begin
                            rx_buffer_next = item.rx_char[6:0];
                            rx_status_next = rx_status_reg | cspr_pkg::BIT_DONE;
                            res.rx_irq     = rx_status_reg[cspr_pkg::BIT_IE_POS];
                        end
                    end
                end
                // transmitter: finish a pending character or give the one-shot
                if (tx_buffer_reg != 8'd0)
                begin
                    tx_status_next = tx_status_reg | cspr_pkg::BIT_DONE;
                    tx_buffer_next = '0;
                    res.tx_irq     = tx_status_reg[cspr_pkg::BIT_IE_POS];
                end
                else if (phase_reg == cspr_pkg::PHASE_ARMED)
                begin
                    res.tx_irq = 1'b1;
                    phase_next = cspr_pkg::PHASE_GIVEN;
                end
            end
            default: ; // unused mode: no effect, zero result
        endcase
    end

    // A transmit buffer write leaves a pending character and a busy transmitter
    a_xbuf_pending: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.tx_valid |=> (tx_buffer_reg & cspr_pkg::PENDING) != 8'd0
                                 && !tx_status_reg[cspr_pkg::BIT_DONE_POS])
        else $error("transmit write did not leave a pending character");

    // A pending character means the transmitter is not ready
    a_pending_busy: assert property (@(posedge clk) disable iff (!rst_n)
        tx_buffer_reg != 8'd0 |-> !tx_status_reg[cspr_pkg::BIT_DONE_POS])
        else $error("pending transmit with ready bit set");

    // Receive interrupt only while the done bit is being set
    a_rx_irq_done: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.rx_irq |=> rx_status_reg[cspr_pkg::BIT_DONE_POS])
        else $error("receive interrupt without done bit");

endmodule

FILE: rtl/console_serial_port_regs.sv
// Top level of the console serial port register block: handshake and pipeline registers.
//
// Usage:
//   Input channel (in_valid / in_ready) carries one beat per bus read, bus
//   write or poll tick: mode, address, write_data, rx_avail, rx_char.
//   Output channel (out_valid / out_ready) returns exactly one result beat
//   per input beat, in order: read_data, bus_error, tx_valid, tx_char,
//   rx_irq, tx_irq.
//   Path: an accepted beat is captured in the input register, processed in a
//   single pass by the core, and its result is captured in the output
//   register when the pipeline advances; out_valid then rises and the
//   result is held there until out_ready takes it.
//   Throughput: one beat per cycle while out_ready is not held low.
//   Stalls: while out_ready is low the held result stays put; the input
//   register still takes one more beat, after which in_ready drops until the
//   output is taken.
//   Reset: all status registers return to their idle values (transmitter
//   ready), both pipeline stages are emptied.
module console_serial_port_regs
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [17:0] address,
    input  logic [15:0] write_data,
    input  logic        rx_avail,
    input  logic [7:0]  rx_char,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] read_data,
    output logic        bus_error,
    output logic        tx_valid,
    output logic [6:0]  tx_char,
    output logic        rx_irq,
    output logic        tx_irq
);

    logic              in_valid_reg;
    cspr_pkg::item_t   item_reg;
    logic              out_valid_reg;
    cspr_pkg::result_t res_reg;
    cspr_pkg::result_t res_next;
    logic              advance;
    logic              fire;

    // Pipeline control
    assign advance  = !out_valid_reg || out_ready;
    assign fire     = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;

    // Input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            item_reg <= '{mode: mode, address: address, write_data: write_data,
                          rx_avail: rx_avail, rx_char: rx_char};
    end

    // Register state and update
    cspr_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item_reg),
        .res   (res_next)
    );

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (fire)
            res_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign read_data = res_reg.read_data;
    assign bus_error = res_reg.bus_error;
    assign tx_valid  = res_reg.tx_valid;
    assign tx_char   = res_reg.tx_char;
    assign rx_irq    = res_reg.rx_irq;
    assign tx_irq    = res_reg.tx_irq;

    // Back-pressure only when both stages are full and the output stalls
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> in_valid_reg && out_valid_reg && !out_ready)
        else $error("input stalled without a full pipeline");

    // A bus error never returns data
    a_berr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bus_error |-> read_data == 16'd0 && !tx_valid)
        else $error("bus error beat carries data");

    // A write and a tick cannot share a beat
    a_tx_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(tx_valid && (tx_irq || rx_irq)))
        else $error("transmit write beat carries an interrupt");

endmodule

FILE: tb/tb_console_serial_port_regs.sv
// Self-checking testbench for the console serial port register block.
`timescale 1ns / 1ps

module tb_console_serial_port_regs;

    // Mode 3 is not decoded by the block; the beat must give an all-zero result
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int unsigned RANDOM_BEATS = 1150;
    localparam int unsigned IDLE_LIMIT = 2000;
    localparam int unsigned TAIL_CYCLES = 8;

    typedef struct {
        cspr_pkg::item_t beat;
        bit              drain_first;
    } queued_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  mode = cspr_pkg::MODE_READ;
    logic [17:0] address = '0;
    logic [15:0] write_data = '0;
    logic        rx_avail = 1'b0;
    logic [7:0]  rx_char = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] read_data;
    logic        bus_error;
    logic        tx_valid;
    logic [6:0]  tx_char;
    logic        rx_irq;
    logic        tx_irq;

    // Shadow copy of the line unit registers
    logic [15:0]         rx_csr;
    logic [15:0]         tx_csr;
    logic [6:0]          rx_hold;
    logic [7:0]          tx_hold;
    cspr_pkg::tx_phase_t oneshot_phase;
    logic                rx_skip;

    queued_beat_t        beat_queue[$];
    cspr_pkg::result_t   expected_results[$];
    logic [17:0]         reg_addrs [4] = '{cspr_pkg::ADDR_RCSR, cspr_pkg::ADDR_RBUF,
                                           cspr_pkg::ADDR_XCSR, cspr_pkg::ADDR_XBUF};

    int unsigned beats_sent = 0;
    int unsigned beats_taken = 0;
    int unsigned gap_left = 0;
    int unsigned burst_left = 1;
    int unsigned idle_cycles = 0;
    int unsigned mismatches = 0;
    logic [15:0] ready_mask = 16'hffff;
    int unsigned ready_idx = 0;
    int unsigned ready_age = 0;

    console_serial_port_regs dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .address    (address),
        .write_data (write_data),
        .rx_avail   (rx_avail),
        .rx_char    (rx_char),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_data  (read_data),
        .bus_error  (bus_error),
        .tx_valid   (tx_valid),
        .tx_char    (tx_char),
        .rx_irq     (rx_irq),
        .tx_irq     (tx_irq)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Register update and result for one beat
    function automatic cspr_pkg::result_t line_unit_result(cspr_pkg::item_t it);
        cspr_pkg::result_t r;
        r = '0;
        case (it.mode)
            cspr_pkg::MODE_READ:
            begin
                case (it.address)
                    cspr_pkg::ADDR_RCSR: r.read_data = rx_csr;
                    cspr_pkg::ADDR_RBUF:
                    begin
                        rx_csr[cspr_pkg::BIT_DONE_POS] = 1'b0;
                        r.read_data = {9'd0, rx_hold};
                    end
                    cspr_pkg::ADDR_XCSR: r.read_data = tx_csr;
                    cspr_pkg::ADDR_XBUF: r.read_data = {8'd0, tx_hold};
                    default:             r.bus_error = 1'b1;
                endcase
            end
            cspr_pkg::MODE_WRITE:
            begin
                case (it.address)
                    cspr_pkg::ADDR_RCSR:
                        rx_csr = (rx_csr & cspr_pkg::BIT_DONE)
                               | (it.write_data & ~cspr_pkg::BIT_DONE);
                    cspr_pkg::ADDR_RBUF: rx_csr[cspr_pkg::BIT_DONE_POS] = 1'b0;
                    cspr_pkg::ADDR_XCSR:
                    begin
                        tx_csr = (tx_csr & cspr_pkg::BIT_DONE)
                               | (it.write_data & ~cspr_pkg::BIT_DONE);
                        if ((tx_csr & cspr_pkg::BITS_DONE_IE) == cspr_pkg::BITS_DONE_IE
                            && oneshot_phase == cspr_pkg::PHASE_IDLE)
                            oneshot_phase = cspr_pkg::PHASE_ARMED;
                        if (oneshot_phase == cspr_pkg::PHASE_GIVEN)
                            oneshot_phase = cspr_pkg::PHASE_IDLE;
                    end
                    cspr_pkg::ADDR_XBUF:
                    begin
                        r.tx_valid = 1'b1;
                        r.tx_char = it.write_data[6:0];
                        tx_hold = {1'b1, it.write_data[6:0]};
                        tx_csr[cspr_pkg::BIT_DONE_POS] = 1'b0;
                        oneshot_phase = cspr_pkg::PHASE_IDLE;
                    end
                    default: r.bus_error = 1'b1;
                endcase
            end
            cspr_pkg::MODE_TICK:
            begin
                // receive side: one skipped tick, then take an offered non-null byte
                if (!rx_csr[cspr_pkg::BIT_DONE_POS])
                begin
                    if (!rx_skip)
                        rx_skip = 1'b1;
                    else if (it.rx_avail)
                    begin
                        rx_skip = 1'b0;
                        if (it.rx_char != 8'd0)
                        begin
                            rx_hold = it.rx_char[6:0];
                            rx_csr[cspr_pkg::BIT_DONE_POS] = 1'b1;
                            r.rx_irq = rx_csr[cspr_pkg::BIT_IE_POS];
                        end
                    end
                end
                // transmit side: finish a pending character or fire the one-shot
                if (tx_hold != 8'd0)
                begin
                    tx_csr[cspr_pkg::BIT_DONE_POS] = 1'b1;
                    tx_hold = 8'd0;
                    r.tx_irq = tx_csr[cspr_pkg::BIT_IE_POS];
                end
                else if (oneshot_phase == cspr_pkg::PHASE_ARMED)
                begin
                    r.tx_irq = 1'b1;
                    oneshot_phase = cspr_pkg::PHASE_GIVEN;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic void add_beat(logic [1:0] m, logic [17:0] a, logic [15:0] wd,
                                     logic av, logic [7:0] ch, bit drain);
        queued_beat_t q;
        q.beat = '{mode: m, address: a, write_data: wd, rx_avail: av, rx_char: ch};
        q.drain_first = drain;
        beat_queue.push_back(q);
    endfunction

    function automatic logic [17:0] pick_address();
        logic [17:0] a;
        case ($urandom_range(0, 19))
            0:       a = 18'($urandom);
            1:       a = reg_addrs[$urandom_range(0, 3)] + 18'd1;
            2:       a = cspr_pkg::ADDR_XBUF + 18'd2;
            3:       a = cspr_pkg::ADDR_RCSR - 18'd2;
            default: a = reg_addrs[$urandom_range(0, 3)];
        endcase
        return a;
    endfunction

    task automatic compare_field(string fname, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, fname, want, got);
        end
    endtask

    // Beat driver: bursts with random gaps, optional drain before a beat
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || beats_taken == beats_sent))
        begin
            if (gap_left != 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (beat_queue.size() != 0 &&
                     !(beat_queue[0].drain_first && expected_results.size() != 0))
            begin
                mode       <= beat_queue[0].beat.mode;
                address    <= beat_queue[0].beat.address;
                write_data <= beat_queue[0].beat.write_data;
                rx_avail   <= beat_queue[0].beat.rx_avail;
                rx_char    <= beat_queue[0].beat.rx_char;
                in_valid   <= 1'b1;
                void'(beat_queue.pop_front());
                beats_sent++;
                burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result sink: random stall pattern re-drawn whenever ready_age wraps, sometimes no stalls
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            ready_age++;
            if (ready_age == 64)
            begin
                ready_age = 0;
                ready_mask = ($urandom_range(0, 2) == 0) ? 16'hffff
                                                         : (16'($urandom) | 16'h0001);
            end
            ready_idx = (ready_idx + 1) % 16;
            out_ready <= ready_mask[ready_idx];
        end
    end

    // Monitor: predict on input beats, check output beats, watchdog
    always @(posedge clk)
    begin
        cspr_pkg::result_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                expected_results.push_back(line_unit_result(cspr_pkg::item_t'{mode: mode,
                    address: address, write_data: write_data, rx_avail: rx_avail,
                    rx_char: rx_char}));
                beats_taken++;
            end
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: result beat with nothing expected", $time);
                end
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("read_data", want.read_data, read_data);
                    compare_field("bus_error", 16'(want.bus_error), 16'(bus_error));
                    compare_field("tx_valid", 16'(want.tx_valid), 16'(tx_valid));
                    compare_field("tx_char", 16'(want.tx_char), 16'(tx_char));
                    compare_field("rx_irq", 16'(want.rx_irq), 16'(rx_irq));
                    compare_field("tx_irq", 16'(want.tx_irq), 16'(tx_irq));
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no beat moved for %0d cycles", IDLE_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        int unsigned n;
        int unsigned sel;
        logic [17:0] a;
        rx_csr = '0;
        tx_csr = 16'h0080;
        rx_hold = '0;
        tx_hold = '0;
        oneshot_phase = cspr_pkg::PHASE_IDLE;
        rx_skip = 1'b0;

        // directed: reset values, bad addresses, receive and transmit paths
        add_beat(cspr_pkg::MODE_READ,  cspr_pkg::ADDR_RCSR, 16'h0000, 1'b0, 8'h00, 1'b0);
        add_beat(cspr_pkg::MODE_READ,  cspr_pkg::ADDR_RBUF, 16'h0000, 1'b0, 8'h00, 1'b0);
        add_beat(cspr_pkg::MODE_READ,  cspr_pkg::ADDR_XCSR, 16'h0000, 1'b0, 8'h00, 1'b0);
        add_beat(cspr_pkg::MODE_READ,  cspr_pkg::ADDR_XBUF, 16'h0000, 1'b0, 8'h00, 1'b0);
        add_beat(cspr_pkg::MODE_READ,  18'h00000,           16'h0000, 1'b0, 8'h00, 1'b0);
        add_beat(cspr_pkg::MODE_WRITE, 18'h3ffff,           16'hffff, 1'b1, 8'hff, 1'b0);
        add_beat(cspr_pkg::MODE_WRITE, cspr_pkg::ADDR_RCSR, 16'hffff, 1'b0, 8'h00, 1'b0);
        add_beat(cspr_pkg::MODE_TICK,  cspr_pkg::ADDR_RCSR, 16'h0000, 1'b1, 8'hff, 1'b0);
        add_beat(cspr_pkg::MODE_TICK,  cspr_pkg::ADDR_RCSR, 16'h0000, 1'b1, 8'hff, 1'b0);
        add_beat(cspr_pkg::MODE_TICK,  cspr_pkg::ADDR_RCSR, 16'h0000, 1'b1, 8'h41, 1'b0);
        add_beat(cspr_pkg::MODE_READ,  cspr_pkg::ADDR_RBUF, 16'h0000, 1'b0, 8'h00, 1'b0);
        add_beat(cspr_pkg::MODE_TICK,  cspr_pkg::ADDR_RCSR, 16'h0000, 1'b0, 8'h00, 1'b0);
        add_beat(cspr_pkg::MODE_TICK,  cspr_pkg::ADDR_RCSR, 16'h0000, 1'b1, 8'h00, 1'b0);
        add_beat(cspr_pkg::MODE_WRITE, cspr_pkg::ADDR_RBUF, 16'hffff, 1'b0, 8'h00, 1'b0);
        add_beat(cspr_pkg::MODE_WRITE, cspr_pkg::ADDR_XCSR, 16'hffff, 1'b0, 8'h00, 1'b0);
        add_beat(cspr_pkg::MODE_TICK,  cspr_pkg::ADDR_XCSR, 16'h0000, 1'b0, 8'h00, 1'b0);
        add_beat(cspr_pkg::MODE_WRITE, cspr_pkg::ADDR_XCSR, 16'h0000, 1'b0, 8'h00, 1'b0);
        add_beat(cspr_pkg::MODE_WRITE, cspr_pkg::ADDR_XCSR, 16'h0040, 1'b0, 8'h00, 1'b0);
        add_beat(cspr_pkg::MODE_WRITE, cspr_pkg::ADDR_XBUF, 16'hffff, 1'b0, 8'h00, 1'b0);
        add_beat(cspr_pkg::MODE_READ,  cspr_pkg::ADDR_XBUF, 16'h0000, 1'b0, 8'h00, 1'b1);
        add_beat(cspr_pkg::MODE_READ,  cspr_pkg::ADDR_XCSR, 16'h0000, 1'b0, 8'h00, 1'b0);
        add_beat(cspr_pkg::MODE_TICK,  cspr_pkg::ADDR_XCSR, 16'h0000, 1'b0, 8'h00, 1'b0);
        add_beat(MODE_UNUSED,          18'h3ffff,           16'hffff, 1'b1, 8'hff, 1'b0);
        add_beat(cspr_pkg::MODE_WRITE, cspr_pkg::ADDR_XBUF, 16'h0000, 1'b0, 8'h00, 1'b0);
        add_beat(cspr_pkg::MODE_TICK,  cspr_pkg::ADDR_XBUF, 16'h0000, 1'b0, 8'h00, 1'b0);
        add_beat(cspr_pkg::MODE_WRITE, cspr_pkg::ADDR_RCSR, 16'h0000, 1'b0, 8'h00, 1'b0);
        add_beat(cspr_pkg::MODE_WRITE, cspr_pkg::ADDR_XCSR, 16'h0000, 1'b0, 8'h00, 1'b0);

        // random mix; ticks are the most frequent kind so the receive path keeps cycling
        n = 0;
        while (n < RANDOM_BEATS)
        begin
            sel = $urandom_range(0, 99);
            a = pick_address();
            if (sel < 3)
                add_beat(MODE_UNUSED, 18'($urandom), 16'($urandom), 1'($urandom),
                         8'($urandom), 1'b0);
            else
            begin
                if (sel < 43)
                    add_beat(cspr_pkg::MODE_TICK, 18'($urandom), 16'($urandom),
                             ($urandom_range(0, 9) < 7),
                             ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom),
                             (n % 300 == 299));
                else if (sel < 71)
                    add_beat(cspr_pkg::MODE_READ, a, 16'($urandom), 1'($urandom),
                             8'($urandom), (n % 300 == 299));
                else
                    add_beat(cspr_pkg::MODE_WRITE, a, 16'($urandom), 1'($urandom),
                             8'($urandom), (n % 300 == 299));
                n++;
            end
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        do
            @(posedge clk);
        while (beat_queue.size() != 0 || beats_taken != beats_sent ||
               expected_results.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
